FILE: rtl/ixs_pkg.sv
// Shared types and constants for the index record sorter.
// Used by ixs_cell and index_record_sorter; no dependencies.
package ixs_pkg;

  localparam int Depth = 64;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int KeyW  = 32;
  localparam int AddrW = 31;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [AddrW-1:0]       address;
  } rec_t;

  typedef struct packed {
    logic load_left;
    logic load_new;
    logic load_right;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

endpackage

FILE: rtl/ixs_cell.sv
// One slot of the sorting chain: holds a record, compares it to the incoming key,
// and loads from its left or right neighbor or from the incoming item.
// Depends on ixs_pkg.
module ixs_cell (
  input  logic              clk_i,
  input  ixs_pkg::cell_ctrl_t ctrl_i,
  input  logic              occ_i,
  input  ixs_pkg::rec_t     left_i,
  input  ixs_pkg::rec_t     right_i,
  input  ixs_pkg::rec_t     new_i,
  output logic              gt_o,
  output ixs_pkg::rec_t     rec_o
);

  ixs_pkg::rec_t rec_d, rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.load_right) begin
      rec_d = right_i;
    end else if (ctrl_i.load_left) begin
      rec_d = left_i;
    end else if (ctrl_i.load_new) begin
      rec_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  // held key strictly above the new one: the new item goes in front of this cell
  assign gt_o  = occ_i && ($signed(rec_q.key) > $signed(new_i.key));
  assign rec_o = rec_q;

endmodule

FILE: rtl/index_record_sorter.sv
// Index record sorter: insertion chain of ixs_cell slots with fill count and drain control.
// Depends on ixs_pkg and ixs_cell.
//
// Takes one record (signed key, address) per cycle while loading; each record drops into
// its sorted place in a chain of 64 cells in the cycle it is accepted, after any held
// records of equal key. The item marked last starts the drain: input stalls, and the held
// records come out of cell 0 smallest key first, one per cycle while the output is not
// stalled, the chain shifting one place toward cell 0 on each result taken. Records arriving
// with the chain full are dropped and raise overflow on every result of that set.
module index_record_sorter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [ixs_pkg::KeyW-1:0]  key_i,
  input  logic [ixs_pkg::AddrW-1:0]  address_i,
  input  logic                       is_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ixs_pkg::KeyW-1:0]  key_res_o,
  output logic [ixs_pkg::AddrW-1:0]  address_res_o,
  output logic                       is_last_res_o,
  output logic                       overflow_o
);

  ixs_pkg::state_e state_d, state_q;
  logic [ixs_pkg::CntW-1:0] count_d, count_q;
  logic dropped_d, dropped_q;

  logic in_acc, out_acc, full, ins_en;
  logic [ixs_pkg::Depth-1:0] gt, occ;
  ixs_pkg::rec_t new_rec;
  ixs_pkg::rec_t cell_rec [ixs_pkg::Depth];
  ixs_pkg::cell_ctrl_t cell_ctrl [ixs_pkg::Depth];

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign full    = (count_q == ixs_pkg::CntW'(ixs_pkg::Depth));
  assign ins_en  = in_acc && !full;
  assign new_rec = '{key: key_i, address: address_i};

  for (genvar i = 0; i < ixs_pkg::Depth; i++) begin : g_cell
    ixs_pkg::rec_t left_rec, right_rec;
    logic gt_prev, occ_prev;

    assign occ[i] = (count_q > ixs_pkg::CntW'(i));

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign gt_prev  = 1'b0;
      assign occ_prev = 1'b1;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign gt_prev  = gt[i-1];
      assign occ_prev = occ[i-1];
    end

    if (i == ixs_pkg::Depth - 1) begin : g_tail
      assign right_rec = new_rec;
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    assign cell_ctrl[i] = '{
      load_left:  ins_en && gt_prev,
      load_new:   ins_en && !gt_prev && occ_prev && (gt[i] || !occ[i]),
      load_right: out_acc
    };

    ixs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .occ_i   (occ[i]),
      .left_i  (left_rec),
      .right_i (right_rec),
      .new_i   (new_rec),
      .gt_o    (gt[i]),
      .rec_o   (cell_rec[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ixs_pkg::ST_LOAD: begin
        if (in_acc && is_last_i) state_d = ixs_pkg::ST_DRAIN;
      end
      ixs_pkg::ST_DRAIN: begin
        if (out_acc && is_last_res_o) state_d = ixs_pkg::ST_LOAD;
      end
      default: state_d = ixs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ixs_pkg::ST_LOAD:  in_stall_o  = 1'b0;
      ixs_pkg::ST_DRAIN: out_valid_o = 1'b1;
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (ins_en) begin
      count_d = count_q + ixs_pkg::CntW'(1);
    end else if (in_acc) begin
      dropped_d = 1'b1;
    end
    if (out_acc) begin
      count_d = count_q - ixs_pkg::CntW'(1);
      if (is_last_res_o) dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ixs_pkg::ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign key_res_o     = cell_rec[0].key;
  assign address_res_o = cell_rec[0].address;
  assign is_last_res_o = (count_q == ixs_pkg::CntW'(1));
  assign overflow_o    = dropped_q;

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("drain with empty chain");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last_i) |=> out_valid_o)
    else $error("last item did not start drain");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && is_last_res_o) |=> (!out_valid_o && count_q == '0 && !dropped_q))
    else $error("drain did not end cleanly");

  a_sorted_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !is_last_res_o) |=>
      (out_valid_o && ($signed(key_res_o) >= $signed($past(key_res_o)))))
    else $error("results out of order");

endmodule
